### sv/hsp_pkg.sv
// shared types and constants for the hashed slot table
`default_nettype none

package hsp_pkg;

   // table size, key width, and first_computer_number width and reset value
   localparam int SLOTS    = 16;
   localparam int KEY_BITS = 16;
   localparam int FCN_BITS = 8;
   localparam logic [FCN_BITS-1:0] FCN_RESET = 8'd21;

   // request codes
   localparam logic [1:0] REQ_PLACE  = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_INSERT = 2'd2;

   // response status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;
   localparam logic [1:0] STAT_DROPPED   = 2'd3;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [KEY_BITS-1:0] key;
   } req_word_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] slot;
      logic [8:0] computer_number;
      logic       moved_valid;
      logic [3:0] moved_slot;
      logic [4:0] removed_count;
   } rsp_word_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_HOME,
      S_DISP,
      S_INS_RD,
      S_OCC,
      S_PROBE_KEEP,
      S_PROBE_DISP,
      S_REM,
      S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       req_take;
      logic       home_set;
      logic       occ_set;
      logic       rd_home;
      logic       scan_start;
      logic       scan_from_zero;
      logic       scan_run;
      logic       wr_en;
      logic       wr_at_chk;
      logic       wr_occ;
      logic       wr_zero;
      logic       count_clr;
      logic       count_inc;
      logic       res_set;
      logic [1:0] res_status;
      logic       res_wrote;
      logic       res_at_chk;
      logic       res_moved;
      logic       rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] req_code;
      logic       key_zero;
      logic       occ_home_eq;
      logic       rd_zero;
      logic       rd_match;
      logic       chk_vld;
      logic       scan_done;
      logic       count_zero;
      logic       out_free;
   } stat_type;

endpackage

`default_nettype wire

### sv/hsp_ram.sv
// generic single write port ram with registered read
`default_nettype none

module hsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/hsp_datapath.sv
// datapath: key store, scan counters and response register
`default_nettype none

module hsp_datapath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire hsp_pkg::cmd_type        cmd,
   output hsp_pkg::stat_type            stat,
   input  wire hsp_pkg::req_word_type   req_data,
   input  wire logic                    csr_valid,
   input  wire logic [hsp_pkg::FCN_BITS-1:0] csr_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output hsp_pkg::rsp_word_type        rsp_data
);

   localparam int SLOTS = hsp_pkg::SLOTS;
   localparam int IW    = $clog2(SLOTS);
   localparam int CW    = $clog2(SLOTS + 1);
   localparam int KB    = hsp_pkg::KEY_BITS;
   localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

   // request and operands
   logic [1:0]    type_ff;
   logic [KB-1:0] key_ff, occ_ff;
   logic [IW-1:0] home_ff;
   logic [hsp_pkg::FCN_BITS-1:0] fcn_ff;

   // scan control
   logic [IW-1:0] scan_addr_ff, scan_addr_in, scan_next;
   logic [CW-1:0] scan_left_ff, scan_left_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [IW-1:0] chk_addr_ff, chk_addr_in;
   logic [IW-1:0] home_next;
   logic [CW-1:0] count_ff;

   // key store with per-entry valid bits (invalid reads as empty)
   logic [SLOTS-1:0] vld_ff;
   logic             rv_ff;
   logic             rd_en, scan_issue;
   logic [IW-1:0]    rd_addr, wr_addr;
   logic [KB-1:0]    wr_data, ram_rdata, rd_word;

   // result holding and output register
   logic [1:0]    res_status_ff;
   logic          res_wrote_ff, res_moved_ff;
   logic [IW-1:0] res_slot_ff, res_mslot_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   hsp_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   hsp_ram #(
      .WIDTH(KB),
      .DEPTH(SLOTS)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (cmd.wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(ram_rdata)
   );

   assign scan_issue = cmd.scan_run & (scan_left_ff != '0);
   assign rd_en      = cmd.rd_home | scan_issue;
   assign rd_addr    = cmd.rd_home ? home_ff : scan_addr_ff;
   assign rd_word    = rv_ff ? ram_rdata : '0;
   assign wr_addr    = cmd.wr_at_chk ? chk_addr_ff : home_ff;
   assign wr_data    = cmd.wr_zero ? '0 : (cmd.wr_occ ? occ_ff : key_ff);

   // scan address walk with wraparound
   assign scan_next = (scan_addr_ff == LAST_SLOT) ? '0 : scan_addr_ff + 1'b1;
   assign home_next = (home_ff == LAST_SLOT) ? '0 : home_ff + 1'b1;

   always_comb begin
      scan_addr_in = scan_addr_ff;
      scan_left_in = scan_left_ff;
      chk_vld_in   = scan_issue;
      chk_addr_in  = scan_addr_ff;
      if (cmd.scan_start) begin
         scan_addr_in = cmd.scan_from_zero ? '0 : home_next;
         scan_left_in = cmd.scan_from_zero ? CW'(SLOTS) : CW'(SLOTS - 1);
         chk_vld_in   = 1'b0;
      end else if (scan_issue) begin
         scan_addr_in = scan_next;
         scan_left_in = scan_left_ff - 1'b1;
      end
   end

   // response word
   always_comb begin
      rsp_word_in                 = '0;
      rsp_word_in.status          = res_status_ff;
      rsp_word_in.slot            = res_wrote_ff ? 4'(res_slot_ff) : 4'd0;
      rsp_word_in.computer_number = res_wrote_ff ? (9'(fcn_ff) + 9'(res_slot_ff)) : 9'd0;
      rsp_word_in.moved_valid     = res_moved_ff;
      rsp_word_in.moved_slot      = res_moved_ff ? 4'(res_mslot_ff) : 4'd0;
      rsp_word_in.removed_count   = 5'(count_ff);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rv_ff        <= 1'b0;
         chk_vld_ff   <= 1'b0;
         scan_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
         fcn_ff       <= hsp_pkg::FCN_RESET;
      end else begin
         if (cmd.wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rv_ff <= vld_ff[rd_addr];
         end
         chk_vld_ff   <= chk_vld_in;
         scan_left_ff <= scan_left_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            fcn_ff <= csr_data;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      chk_addr_ff  <= chk_addr_in;
      if (cmd.req_take) begin
         type_ff <= req_data.req_type;
         key_ff  <= req_data.key;
      end
      // slot count is a power of two, so the home slot is the low key bits
      if (cmd.home_set) begin
         home_ff <= key_ff[IW-1:0];
      end
      if (cmd.occ_set) begin
         occ_ff <= rd_word;
      end
      if (cmd.count_clr) begin
         count_ff <= '0;
      end else if (cmd.count_inc) begin
         count_ff <= count_ff + 1'b1;
      end
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         res_wrote_ff  <= cmd.res_wrote;
         res_slot_ff   <= cmd.res_at_chk ? chk_addr_ff : home_ff;
         res_moved_ff  <= cmd.res_moved;
         res_mslot_ff  <= chk_addr_ff;
      end
      if (cmd.rsp_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign stat.req_code    = type_ff;
   assign stat.key_zero    = (key_ff == '0);
   assign stat.occ_home_eq = (occ_ff[IW-1:0] == home_ff);
   assign stat.rd_zero     = (rd_word == '0);
   assign stat.rd_match    = (rd_word == key_ff);
   assign stat.chk_vld     = chk_vld_ff;
   assign stat.scan_done   = ~chk_vld_ff & (scan_left_ff == '0);
   assign stat.count_zero  = (count_ff == '0);
   assign stat.out_free    = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

endmodule

`default_nettype wire

### sv/hsp_ctrl.sv
// controller state machine for the hashed slot table
`default_nettype none

module hsp_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire hsp_pkg::stat_type stat,
   output hsp_pkg::cmd_type       cmd
);

   hsp_pkg::state_type state_ff, state_in;
   logic probe_hit, rem_hit;

   assign probe_hit = stat.chk_vld & stat.rd_zero;
   assign rem_hit   = stat.chk_vld & stat.rd_match;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hsp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hsp_pkg::S_IDLE: begin
            if (req_valid) state_in = hsp_pkg::S_HOME;
         end
         hsp_pkg::S_HOME: begin
            state_in = hsp_pkg::S_DISP;
         end
         hsp_pkg::S_DISP: begin
            unique case (stat.req_code)
               hsp_pkg::REQ_REMOVE: begin
                  state_in = stat.key_zero ? hsp_pkg::S_DONE : hsp_pkg::S_REM;
               end
               hsp_pkg::REQ_INSERT: begin
                  state_in = stat.key_zero ? hsp_pkg::S_DONE : hsp_pkg::S_INS_RD;
               end
               default: state_in = hsp_pkg::S_DONE;
            endcase
         end
         hsp_pkg::S_INS_RD: begin
            state_in = stat.rd_zero ? hsp_pkg::S_DONE : hsp_pkg::S_OCC;
         end
         hsp_pkg::S_OCC: begin
            state_in = stat.occ_home_eq ? hsp_pkg::S_PROBE_KEEP : hsp_pkg::S_PROBE_DISP;
         end
         hsp_pkg::S_PROBE_KEEP, hsp_pkg::S_PROBE_DISP: begin
            if (probe_hit || stat.scan_done) state_in = hsp_pkg::S_DONE;
         end
         hsp_pkg::S_REM: begin
            if (stat.scan_done) state_in = hsp_pkg::S_DONE;
         end
         hsp_pkg::S_DONE: begin
            if (stat.out_free) state_in = hsp_pkg::S_IDLE;
         end
         default: state_in = hsp_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         hsp_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_take  = 1'b1;
               cmd.count_clr = 1'b1;
            end
         end
         hsp_pkg::S_HOME: begin
            cmd.home_set = 1'b1;
         end
         hsp_pkg::S_DISP: begin
            unique case (stat.req_code)
               hsp_pkg::REQ_PLACE: begin
                  cmd.wr_en      = 1'b1;
                  cmd.res_set    = 1'b1;
                  cmd.res_status = hsp_pkg::STAT_OK;
                  cmd.res_wrote  = 1'b1;
               end
               hsp_pkg::REQ_REMOVE: begin
                  if (stat.key_zero) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = hsp_pkg::STAT_NOT_FOUND;
                  end else begin
                     cmd.scan_start     = 1'b1;
                     cmd.scan_from_zero = 1'b1;
                  end
               end
               hsp_pkg::REQ_INSERT: begin
                  if (stat.key_zero) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = hsp_pkg::STAT_OK;
                     cmd.res_wrote  = 1'b1;
                  end else begin
                     cmd.rd_home = 1'b1;
                  end
               end
               default: begin
                  cmd.res_set    = 1'b1;
                  cmd.res_status = hsp_pkg::STAT_OK;
               end
            endcase
         end
         hsp_pkg::S_INS_RD: begin
            if (stat.rd_zero) begin
               cmd.wr_en      = 1'b1;
               cmd.res_set    = 1'b1;
               cmd.res_status = hsp_pkg::STAT_OK;
               cmd.res_wrote  = 1'b1;
            end else begin
               cmd.occ_set = 1'b1;
            end
         end
         hsp_pkg::S_OCC: begin
            cmd.scan_start = 1'b1;
            cmd.wr_en      = ~stat.occ_home_eq;
         end
         hsp_pkg::S_PROBE_KEEP: begin
            cmd.scan_run = 1'b1;
            if (probe_hit) begin
               cmd.wr_en      = 1'b1;
               cmd.wr_at_chk  = 1'b1;
               cmd.res_set    = 1'b1;
               cmd.res_status = hsp_pkg::STAT_OK;
               cmd.res_wrote  = 1'b1;
               cmd.res_at_chk = 1'b1;
               cmd.res_moved  = 1'b1;
            end else if (stat.scan_done) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = hsp_pkg::STAT_FULL;
            end
         end
         hsp_pkg::S_PROBE_DISP: begin
            cmd.scan_run = 1'b1;
            if (probe_hit) begin
               cmd.wr_en      = 1'b1;
               cmd.wr_at_chk  = 1'b1;
               cmd.wr_occ     = 1'b1;
               cmd.res_set    = 1'b1;
               cmd.res_status = hsp_pkg::STAT_OK;
               cmd.res_wrote  = 1'b1;
               cmd.res_moved  = 1'b1;
            end else if (stat.scan_done) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = hsp_pkg::STAT_DROPPED;
               cmd.res_wrote  = 1'b1;
            end
         end
         hsp_pkg::S_REM: begin
            cmd.scan_run = 1'b1;
            if (rem_hit) begin
               cmd.wr_en     = 1'b1;
               cmd.wr_at_chk = 1'b1;
               cmd.wr_zero   = 1'b1;
               cmd.count_inc = 1'b1;
            end
            if (stat.scan_done) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = stat.count_zero ? hsp_pkg::STAT_NOT_FOUND : hsp_pkg::STAT_OK;
            end
         end
         hsp_pkg::S_DONE: begin
            cmd.rsp_load = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

### sv/hash_slot_probe_replace.sv
// top level of the hashed slot table with probing and replacement
// one request in flight; the key ram's single read port sweeps or probes one slot per cycle
// the block turns ready for the next word as the response word is registered; a stalled response
//   word holds the block in its hand-off state
// reset (synchronous) empties the table at once through per-slot valid bits and sets first_computer_number to 21
`default_nettype none

module hash_slot_probe_replace (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request words
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire hsp_pkg::req_word_type        req_data,
   // response words
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output hsp_pkg::rsp_word_type             rsp_data,
   // first_computer_number register
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [hsp_pkg::FCN_BITS-1:0] csr_data
);

   hsp_pkg::cmd_type  cmd;
   hsp_pkg::stat_type stat;

   // register writes are to arrive only while idle (not enforced by the block); the port never stalls
   assign csr_ready = 1'b1;

   // sequencer: home slot, dispatch, probe or sweep, response hand-off
   hsp_ctrl u_hsp_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   // key ram, scan counters and output register
   // slot links never reach a response, so no link store is kept
   hsp_datapath u_hsp_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_data (req_data),
      .csr_valid(csr_valid),
      .csr_data (csr_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

### sv/hsp_checker.sv
// port checker for the hashed slot table, bound to the top level
`default_nettype none

module hsp_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire hsp_pkg::req_word_type        req_data,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire hsp_pkg::rsp_word_type        rsp_data,
   input wire logic                         csr_valid,
   input wire logic                         csr_ready,
   input wire logic [hsp_pkg::FCN_BITS-1:0] csr_data
);

   // a stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // nothing is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a remove that finds nothing reports no slot and no move
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == hsp_pkg::STAT_NOT_FOUND |->
         rsp_data.removed_count == 5'd0 && rsp_data.slot == 4'd0 && !rsp_data.moved_valid)
      else $error("not-found response carries data");

   // a full table stores nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == hsp_pkg::STAT_FULL |->
         rsp_data.slot == 4'd0 && rsp_data.computer_number == 9'd0 && !rsp_data.moved_valid)
      else $error("full-table response carries a slot");

   // moved slot only shows with a move
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.moved_valid |-> rsp_data.moved_slot == 4'd0)
      else $error("moved slot without a move");

endmodule

bind hash_slot_probe_replace hsp_checker u_hsp_checker (.*);

`default_nettype wire
